// ===== rtl/apu_pkg.sv =====
// Shared types and constants for the alpha premultiply unit.
// No dependencies; used by every module under rtl/.
package apu_pkg;

  localparam int unsigned ChanW   = 8;             // bits per pixel channel
  localparam int unsigned DivW    = 2 * ChanW;     // dividend / quotient width
  localparam int unsigned NumChan = 3;             // colour channels: red, green, blue
  localparam int unsigned NumCells = DivW;         // one quotient bit per cell

  localparam logic [ChanW-1:0] FullScale = 8'd255;

  localparam logic ModePremul = 1'b0;
  localparam logic ModeUndo   = 1'b1;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    logic [ChanW-1:0] alpha_in;
  } apu_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic [ChanW-1:0] alpha_out;
  } apu_out_t;

  // Per-channel division state: partial remainder plus a shift word that
  // holds the unused dividend bits on top and the quotient bits below.
  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [DivW-1:0]  dq;
  } apu_chan_t;

  // What one cell hands to its neighbor. ch[0] red, ch[1] green, ch[2] blue.
  typedef struct packed {
    apu_chan_t [NumChan-1:0] ch;
    logic [ChanW-1:0]        divisor;
    logic [ChanW-1:0]        alpha;
  } apu_cell_t;

endpackage

// ===== rtl/apu_mul_stage.sv =====
// Front stage: forms the dividend of each colour channel and their shared divisor.
// Depends on apu_pkg.
module apu_mul_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               mode_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  apu_pkg::apu_in_t   data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output apu_pkg::apu_cell_t data_o
);

  logic                     valid_q;
  apu_pkg::apu_cell_t       data_q;
  apu_pkg::apu_cell_t       data_d;
  logic [apu_pkg::ChanW-1:0] chan_in [apu_pkg::NumChan];
  logic                     alpha_zero;

  assign chan_in[0] = data_i.red_in;
  assign chan_in[1] = data_i.green_in;
  assign chan_in[2] = data_i.blue_in;
  assign alpha_zero = (data_i.alpha_in == '0);

  always_comb begin
    data_d.alpha = data_i.alpha_in;
    if (mode_i == apu_pkg::ModeUndo) begin
      // zero alpha: divide by one so the colour comes out as it went in
      data_d.divisor = alpha_zero ? apu_pkg::ChanW'(1) : data_i.alpha_in;
    end else begin
      data_d.divisor = apu_pkg::FullScale;
    end
    for (int c = 0; c < apu_pkg::NumChan; c++) begin
      data_d.ch[c].rem = '0;
      if (mode_i == apu_pkg::ModeUndo) begin
        if (alpha_zero) begin
          data_d.ch[c].dq = {{apu_pkg::ChanW{1'b0}}, chan_in[c]};
        end else begin
          // c * 255 = (c << 8) - c
          data_d.ch[c].dq = {chan_in[c], {apu_pkg::ChanW{1'b0}}}
                          - {{apu_pkg::ChanW{1'b0}}, chan_in[c]};
        end
      end else begin
        data_d.ch[c].dq = apu_pkg::DivW'(chan_in[c]) * apu_pkg::DivW'(data_i.alpha_in);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/apu_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit for all three channels.
// Depends on apu_pkg.
module apu_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  apu_pkg::apu_cell_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output apu_pkg::apu_cell_t data_o
);

  logic                       valid_q;
  apu_pkg::apu_cell_t         data_q;
  apu_pkg::apu_cell_t         data_d;
  logic [apu_pkg::ChanW:0]    shifted [apu_pkg::NumChan];
  logic [apu_pkg::ChanW:0]    diff    [apu_pkg::NumChan];
  logic                       fits    [apu_pkg::NumChan];

  always_comb begin
    data_d.divisor = data_i.divisor;
    data_d.alpha   = data_i.alpha;
    for (int c = 0; c < apu_pkg::NumChan; c++) begin
      shifted[c] = {data_i.ch[c].rem, data_i.ch[c].dq[apu_pkg::DivW-1]};
      diff[c]    = shifted[c] - {1'b0, data_i.divisor};
      fits[c]    = (shifted[c] >= {1'b0, data_i.divisor});
      data_d.ch[c].rem = fits[c] ? diff[c][apu_pkg::ChanW-1:0]
                                 : shifted[c][apu_pkg::ChanW-1:0];
      data_d.ch[c].dq  = {data_i.ch[c].dq[apu_pkg::DivW-2:0], fits[c]};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

`ifndef SYNTHESIS
  // a held item must not change while the neighbor stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(data_q))
    else $error("div cell lost or changed a stalled item");

  // divisor is never zero inside the chain (zero alpha is remapped up front)
  a_div_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> data_q.divisor != '0)
    else $error("zero divisor in div chain");

  // partial remainders stay below the divisor
  a_rem_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (data_q.ch[0].rem < data_q.divisor) &&
                (data_q.ch[1].rem < data_q.divisor) &&
                (data_q.ch[2].rem < data_q.divisor))
    else $error("remainder out of range");
`endif

endmodule

// ===== rtl/alpha_premultiply_unit.sv =====
// Pipeline: 1 product stage + 16 div cells, each with its own register; ready ripples back.
// Throughput: one pixel per cycle unless the output stalls.
// Stall on the output fills bubbles first, then backpressures the input.
// Reset (rst_ni, async, active low): all stage valids clear, mode returns to premultiply.
// Mode is sampled with each pixel at the product stage.
// Depends on apu_pkg, apu_mul_stage, apu_div_cell.
module alpha_premultiply_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  // config
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  // pixel in
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  apu_pkg::apu_in_t in_data_i,
  // pixel out
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output apu_pkg::apu_out_t out_data_o
);

  logic mode_q;

  // stage k drives index k; index 0 is the product stage output
  logic               valid_s [apu_pkg::NumCells+1];
  logic               ready_s [apu_pkg::NumCells+1];
  apu_pkg::apu_cell_t data_s  [apu_pkg::NumCells+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= apu_pkg::ModePremul;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Premultiply: dividend c*alpha, divisor 255.
  // Undo: dividend c*255, divisor alpha (alpha zero -> divisor 1, dividend c).
  apu_mul_stage u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (mode_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .data_o  (data_s[0])
  );

  // 16 cells, MSB-first restoring division; the quotient ends in dq.
  for (genvar k = 0; k < apu_pkg::NumCells; k++) begin : g_cell
    apu_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .data_i  (data_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .data_o  (data_s[k+1])
    );
  end

  assign ready_s[apu_pkg::NumCells] = out_ready_i;
  assign out_valid_o = valid_s[apu_pkg::NumCells];

  // quotient can exceed 255 in undo mode; low byte only (wraps)
  assign out_data_o.red_out   = data_s[apu_pkg::NumCells].ch[0].dq[apu_pkg::ChanW-1:0];
  assign out_data_o.green_out = data_s[apu_pkg::NumCells].ch[1].dq[apu_pkg::ChanW-1:0];
  assign out_data_o.blue_out  = data_s[apu_pkg::NumCells].ch[2].dq[apu_pkg::ChanW-1:0];
  assign out_data_o.alpha_out = data_s[apu_pkg::NumCells].alpha;

`ifndef SYNTHESIS
  // input only backs up once the whole chain, output included, is full
  a_full_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with room in the chain");

  // an idle output register never blocks the chain
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> ready_s[apu_pkg::NumCells-1])
    else $error("last cell stalled behind empty output");

  // product stage holds its item across a stall
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_s[0] && !ready_s[0] |=> valid_s[0] && $stable(data_s[0]))
    else $error("product stage dropped a stalled item");
`endif

endmodule

// ===== verif/tb.sv =====
// Testbench for alpha_premultiply_unit: RGBA pixel transfers checked against
// a local premultiply / unpremultiply calculation. Needs rtl/apu_pkg.sv and the unit.
`timescale 1ns / 1ps

module tb;

  // Longest run of cycles with no transfer on either side before giving up.
  localparam int StallLimit = 5000;
  // Output hold-off, well past the pipeline depth of 17 stages.
  localparam int HoldCycles = 60;
  // Cycles to keep watching after the last pixel came back.
  localparam int TailCycles = 24;
  localparam int PerSegment = 144;
  localparam int NumRows    = 17;

  // Idling per phase: none, sender only, receiver only, both.
  localparam int SendIdle [4] = '{0, 77, 0, 22};
  localparam int RecvStall [4] = '{0, 0, 77, 22};

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  apu_pkg::apu_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  apu_pkg::apu_out_t out_data_o;

  // Stimulus rows: mode, input pixel, and a typed-in answer where it is obvious
  // (opaque, fully transparent, zero alpha in undo, wrap at alpha 1).
  typedef struct {
    logic              mode;
    apu_pkg::apu_in_t  px;
    logic              typed;
    apu_pkg::apu_out_t want;
  } pixel_row_t;

  pixel_row_t dir_rows [NumRows] = '{
    '{apu_pkg::ModePremul, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{apu_pkg::ModePremul, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{apu_pkg::ModePremul, 32'hFF80_0100, 1'b1, 32'h0000_0000},  // transparent -> black
    '{apu_pkg::ModePremul, 32'h1234_56FF, 1'b1, 32'h1234_56FF},  // opaque -> unchanged
    '{apu_pkg::ModePremul, 32'hFFFF_FF01, 1'b1, 32'h0101_0101},
    '{apu_pkg::ModePremul, 32'hAA55_0F80, 1'b0, 32'h0},
    '{apu_pkg::ModePremul, 32'h01FE_7FFE, 1'b0, 32'h0},
    '{apu_pkg::ModeUndo,   32'h0000_0000, 1'b1, 32'h0000_0000},
    '{apu_pkg::ModeUndo,   32'hFF80_0100, 1'b1, 32'hFF80_0100},  // zero alpha passes colors
    '{apu_pkg::ModeUndo,   32'h1234_56FF, 1'b1, 32'h1234_56FF},
    '{apu_pkg::ModeUndo,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{apu_pkg::ModeUndo,   32'hFF02_0101, 1'b1, 32'h01FE_FF01},  // quotient wraps, no clamp
    '{apu_pkg::ModeUndo,   32'h8040_0140, 1'b0, 32'h0},
    '{apu_pkg::ModeUndo,   32'h55AA_00AA, 1'b0, 32'h0},
    '{apu_pkg::ModeUndo,   32'h00FF_7F80, 1'b0, 32'h0},
    '{apu_pkg::ModePremul, 32'h7F80_FE7F, 1'b0, 32'h0},
    '{apu_pkg::ModePremul, 32'h0102_03FE, 1'b0, 32'h0}
  };

  apu_pkg::apu_out_t pending_pixels [$];  // converted pixels not yet seen at the output
  apu_pkg::apu_out_t want_px;
  logic     mode_q;              // our copy of the mode register
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  logic     hold_req = 1'b0;     // asks the receiver for one long hold-off

  alpha_premultiply_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One color channel. Premultiply: c*a/255. Undo: c*255/a keeping the low
  // byte, with zero alpha leaving the channel alone.
  function automatic logic [apu_pkg::ChanW-1:0] scale_chan(
      logic [apu_pkg::ChanW-1:0] c, logic [apu_pkg::ChanW-1:0] a, logic undo);
    logic [apu_pkg::DivW-1:0] prod;
    logic [apu_pkg::DivW-1:0] quot;
    if (undo == apu_pkg::ModeUndo) begin
      if (a == '0) return c;
      prod = apu_pkg::DivW'(c) * apu_pkg::DivW'(apu_pkg::FullScale);
      quot = prod / apu_pkg::DivW'(a);
    end else begin
      prod = apu_pkg::DivW'(c) * apu_pkg::DivW'(a);
      quot = prod / apu_pkg::DivW'(apu_pkg::FullScale);
    end
    return quot[apu_pkg::ChanW-1:0];
  endfunction

  function automatic apu_pkg::apu_out_t convert_pixel(apu_pkg::apu_in_t px, logic undo);
    apu_pkg::apu_out_t res;
    res.red_out   = scale_chan(px.red_in, px.alpha_in, undo);
    res.green_out = scale_chan(px.green_in, px.alpha_in, undo);
    res.blue_out  = scale_chan(px.blue_in, px.alpha_in, undo);
    res.alpha_out = px.alpha_in;
    return res;
  endfunction

  // Mostly random bits; alpha leans toward 0, 255 and tiny values (the wrap
  // region in undo), and a quarter of pixels are well formed: color <= alpha.
  function automatic apu_pkg::apu_in_t random_pixel();
    apu_pkg::apu_in_t px;
    px = apu_pkg::apu_in_t'($urandom());
    case ($urandom_range(7))
      0: px.alpha_in = '0;
      1: px.alpha_in = '1;
      2: px.alpha_in = apu_pkg::ChanW'($urandom_range(3));
      default: ;
    endcase
    if ($urandom_range(3) == 0) begin
      px.red_in   = apu_pkg::ChanW'($urandom_range(px.alpha_in));
      px.green_in = apu_pkg::ChanW'($urandom_range(px.alpha_in));
      px.blue_in  = apu_pkg::ChanW'($urandom_range(px.alpha_in));
    end
    return px;
  endfunction

  // Present one pixel after a random gap and hold it until the transfer.
  task automatic send_pixel(apu_pkg::apu_in_t px, logic typed, apu_pkg::apu_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= apu_pkg::apu_in_t'($urandom());  // junk while idle
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pixels.push_back(typed ? want : convert_pixel(px, mode_q));
  endtask

  // Stop offering and let every outstanding pixel come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Mode changes only with the pipeline empty.
  task automatic write_mode(logic m);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_q = m;
  endtask

  task automatic check_chan(string name, logic [apu_pkg::ChanW-1:0] want,
                            logic [apu_pkg::ChanW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Output side: every transfer is matched against the oldest pending pixel.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, got %08h", $time, out_data_o);
        mismatches++;
      end else begin
        want_px = pending_pixels.pop_front();
        check_chan("red",   want_px.red_out,   out_data_o.red_out);
        check_chan("green", want_px.green_out, out_data_o.green_out);
        check_chan("blue",  want_px.blue_out,  out_data_o.blue_out);
        check_chan("alpha", want_px.alpha_out, out_data_o.alpha_out);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so the
  // pipeline fills and pushes back on the input.
  initial begin : receiver
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= rst_ni && ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: too long without any transfer means the unit hung.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    mode_q      = apu_pkg::ModePremul;  // reset value
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels: extremes, both modes, zero alpha and wrap cases.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != mode_q) write_mode(dir_rows[i].mode);
      send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random pixels: each idling phase once per mode.
    for (int seg = 0; seg < 8; seg++) begin
      write_mode(seg[0] ? apu_pkg::ModeUndo : apu_pkg::ModePremul);
      send_idle_pct = SendIdle[seg / 2];
      stall_pct     = RecvStall[seg / 2];
      for (int n = 0; n < PerSegment; n++) begin
        // back-to-back input while the output is held off: pipeline fills
        if (seg == 0 && n == 20) hold_req = 1'b1;
        // sender waits out every pixel in flight once
        if (seg == 2 && n == 70) wait_drained();
        send_pixel(random_pixel(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/apu_pkg.sv
rtl/apu_mul_stage.sv
rtl/apu_div_cell.sv
rtl/alpha_premultiply_unit.sv
verif/tb.sv
